// ===== hw/rtl/bhpq_pkg.sv =====
// Shared types and codes for the binary heap priority queue.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bhpq_pkg;

  // opcode field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // status field
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // heap_order register
  localparam logic ORDER_MAX = 1'b0;
  localparam logic ORDER_MIN = 1'b1;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PADDR_W  = 2;
  localparam int unsigned PDATA_W  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_UP_FIN,
    ST_DN_LAST,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/bhpq_if.sv =====
// Valid/ready channel interfaces for the heap request and result words.
// Depends on bhpq_pkg for the field widths.
`timescale 1ns / 1ps

interface bhpq_in_if;
  logic                           valid;
  logic                           ready;
  logic [bhpq_pkg::OPCODE_W-1:0]  opcode;
  logic signed [bhpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bhpq_out_if;
  logic                                valid;
  logic                                ready;
  logic [bhpq_pkg::STATUS_W-1:0]       status;
  logic signed [bhpq_pkg::VALUE_W-1:0] top_value;
  logic [bhpq_pkg::COUNT_W-1:0]        element_count;

  modport source (output valid, output status, output top_value, output element_count,
                  input ready);
  modport sink   (input valid, input status, input top_value, input element_count,
                  output ready);
endinterface

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// Binary heap priority queue: one heap memory with two read ports, sift FSM, APB register.
// Depends on bhpq_pkg and the channel interfaces in bhpq_if.sv.
`timescale 1ns / 1ps

// Usage:
//   req (sink): opcode 0 inserts value, opcode 1 removes the top element.
//   rsp (source): one word per request: status, root after the operation, element count.
//   APB register 0, bit 0 (heap_order): 0 max on top, 1 min on top. Write it only
//   while no request is in flight; stored elements are not reordered by a change.
// Operation:
//   One request at a time; req.ready is high only while the block is idle.
//   Insert: the element climbs L levels (at most log2(DEPTH)), the read of each next parent
//   overlapping the write of the level before; then the result register loads.
//   Remove: the last element moves to the root and descends L levels; both children
//   come from the two read ports of the heap memory in the same cycle. Status-only cases,
//   an insert into an empty heap and a remove of the last element go straight to the load.
//   req.ready returns the cycle after the load, so the block takes no new request
//   in the cycle in which it loads a result.
// Stall: the result waits in its output register; the block returns to idle only
//   once that register is free, so a stalled receiver holds back the next request.
// Reset: count, heap_order and the handshake clear; the heap memory is not cleared
//   and no entry at or above count is ever used.
module binary_heap_priority_queue #(
  parameter int unsigned DEPTH       = 128,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  bhpq_in_if.sink                       req,
  bhpq_out_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhpq_pkg::PADDR_W-1:0]  paddr,
  input  logic [bhpq_pkg::PDATA_W-1:0]  pwdata,
  output logic [bhpq_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = AW + 2;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam logic [VW-1:0] SIGN = {1'b1, {(VW-1){1'b0}}};

  // heap memory, entries kept with the sign bit flipped for unsigned compare
  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rd_a, rd_b;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [VW-1:0] wdata;
  logic          we;

  bhpq_pkg::state_t state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [VW-1:0] elem, elem_next;
  logic [CW-1:0] count, count_next;
  logic [VW-1:0] root;
  logic [1:0]    status_reg, status_next;
  logic          heap_order;

  logic                               out_valid, out_load;
  logic [bhpq_pkg::STATUS_W-1:0]      out_status;
  logic [bhpq_pkg::VALUE_W-1:0]       out_top;
  logic [bhpq_pkg::COUNT_W-1:0]       out_count;

  function automatic logic better(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                  input logic order);
    better = (order == bhpq_pkg::ORDER_MIN) ? (a < b) : (a > b);
  endfunction

  function automatic logic [AW-1:0] parent(input logic [AW-1:0] i);
    parent = AW'((i - AW'(1)) >> 1);
  endfunction

  // ---- APB register ----
  assign pready = 1'b1;
  assign prdata = {{(bhpq_pkg::PDATA_W-1){1'b0}}, heap_order};

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_order <= bhpq_pkg::ORDER_MAX;
    end else if (psel && penable && pwrite && pready) begin
      heap_order <= pwdata[0];
    end
  end

  // ---- heap memory ----
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // input value: low VW bits, sign flipped
  logic [VW+bhpq_pkg::VALUE_W-1:0] vin_wide;
  logic [VW-1:0]                   vin;
  assign vin_wide = {{VW{1'b0}}, req.value};
  assign vin      = vin_wide[VW-1:0] ^ SIGN;

  logic [AW-1:0] cnt_idx;
  assign cnt_idx = count[AW-1:0];

  // sift-down child selection
  logic [LW-1:0] lch, rch, cnt_ext;
  logic          take_r;
  logic [AW-1:0] c_idx;
  logic [VW-1:0] c_val;
  logic [AW:0]   c_left;

  always_comb begin
    lch     = LW'({idx, 1'b1});
    rch     = lch + LW'(1);
    cnt_ext = LW'(count);
    take_r  = (rch < cnt_ext) && better(rd_b, rd_a, heap_order);
    c_idx   = take_r ? rch[AW-1:0] : lch[AW-1:0];
    c_val   = take_r ? rd_b : rd_a;
    c_left  = {c_idx, 1'b1};
  end

  assign req.ready = (state == bhpq_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    elem_next   = elem;
    count_next  = count;
    status_next = status_reg;
    we          = 1'b0;
    waddr       = idx;
    wdata       = elem;
    raddr_a     = '0;
    raddr_b     = '0;
    out_load    = 1'b0;

    unique case (state)
      bhpq_pkg::ST_IDLE: begin
        if (req.valid) begin
          status_next = bhpq_pkg::STATUS_DONE;
          state_next  = bhpq_pkg::ST_DONE;
          if (req.opcode == bhpq_pkg::OP_INSERT) begin
            if (count == CW'(DEPTH)) begin
              status_next = bhpq_pkg::STATUS_FULL;
            end else begin
              elem_next  = vin;
              idx_next   = cnt_idx;
              count_next = count + CW'(1);
              if (cnt_idx == '0) begin
                we    = 1'b1;
                waddr = '0;
                wdata = vin;
              end else begin
                raddr_a    = parent(cnt_idx);
                state_next = bhpq_pkg::ST_UP_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              status_next = bhpq_pkg::STATUS_EMPTY;
            end else begin
              count_next = count - CW'(1);
              if (count != CW'(1)) begin
                raddr_a    = AW'(count - CW'(1));
                state_next = bhpq_pkg::ST_DN_LAST;
              end
            end
          end
        end
      end

      bhpq_pkg::ST_UP_CMP: begin
        we = 1'b1;
        if (better(elem, rd_a, heap_order)) begin
          // parent moves down into the hole
          wdata    = rd_a;
          idx_next = parent(idx);
          if (parent(idx) == '0) begin
            state_next = bhpq_pkg::ST_UP_FIN;
          end else begin
            raddr_a = parent(parent(idx));
          end
        end else begin
          state_next = bhpq_pkg::ST_DONE;
        end
      end

      bhpq_pkg::ST_UP_FIN: begin
        we         = 1'b1;
        waddr      = '0;
        state_next = bhpq_pkg::ST_DONE;
      end

      bhpq_pkg::ST_DN_LAST: begin
        elem_next  = rd_a;
        idx_next   = '0;
        raddr_a    = AW'(1);
        raddr_b    = AW'(2);
        state_next = bhpq_pkg::ST_DN_CMP;
      end

      bhpq_pkg::ST_DN_CMP: begin
        we = 1'b1;
        if (lch >= cnt_ext) begin
          state_next = bhpq_pkg::ST_DONE;
        end else if (better(c_val, elem, heap_order)) begin
          // better child moves up into the hole
          wdata    = c_val;
          idx_next = c_idx;
          raddr_a  = AW'(c_left);
          raddr_b  = AW'(c_left + (AW+1)'(1));
        end else begin
          state_next = bhpq_pkg::ST_DONE;
        end
      end

      bhpq_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = bhpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bhpq_pkg::ST_IDLE;
      end
    endcase
  end

  // result fields
  logic [VW+bhpq_pkg::VALUE_W-1:0] top_wide;
  logic [CW+bhpq_pkg::COUNT_W-1:0] cnt_wide;
  assign top_wide = {{bhpq_pkg::VALUE_W{1'b0}}, root ^ SIGN};
  assign cnt_wide = {{bhpq_pkg::COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bhpq_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    elem       <= elem_next;
    status_reg <= status_next;
    if (we && waddr == '0) begin
      root <= wdata;
    end
    if (out_load) begin
      out_status <= status_reg;
      out_top    <= (count == '0) ? '0 : top_wide[bhpq_pkg::VALUE_W-1:0];
      out_count  <= cnt_wide[bhpq_pkg::COUNT_W-1:0];
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.top_value     = out_top;
  assign rsp.element_count = out_count;

endmodule

// ===== dv/binary_heap_priority_queue_tb.sv =====
// Self-checking bench for binary_heap_priority_queue: insert/remove words with random
// idling on both channels, heap order switched over APB, results checked against a shadow heap.
// Depends on bhpq_pkg and the bhpq_in_if / bhpq_out_if interfaces.
`timescale 1ns / 1ps

module binary_heap_priority_queue_tb;

  localparam int unsigned HEAP_DEPTH = 128;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic [bhpq_pkg::PADDR_W-1:0] HEAP_ORDER_ADDR = '0;
  localparam logic signed [bhpq_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [bhpq_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic [bhpq_pkg::STATUS_W-1:0] status;
    logic [bhpq_pkg::VALUE_W-1:0]  top_value;
    logic [bhpq_pkg::COUNT_W-1:0]  element_count;
  } heap_reply_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bhpq_pkg::PADDR_W-1:0] paddr;
  logic [bhpq_pkg::PDATA_W-1:0] pwdata;
  logic [bhpq_pkg::PDATA_W-1:0] prdata;
  logic pready;

  bhpq_in_if  req_if ();
  bhpq_out_if rsp_if ();

  binary_heap_priority_queue #(
    .DEPTH      (HEAP_DEPTH),
    .VALUE_WIDTH(bhpq_pkg::VALUE_W)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_if),
    .rsp    (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the heap, updated when a request word is accepted
  logic signed [bhpq_pkg::VALUE_W-1:0] shadow_heap [HEAP_DEPTH];
  int                                  shadow_count = 0;
  logic                                shadow_order = bhpq_pkg::ORDER_MAX;

  heap_reply_t queued_heap_replies [$];
  heap_reply_t want_reply;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct;
  int          recv_idle_pct;

  function automatic bit ranks_above(input logic signed [bhpq_pkg::VALUE_W-1:0] a,
                                     input logic signed [bhpq_pkg::VALUE_W-1:0] b);
    return (shadow_order == bhpq_pkg::ORDER_MIN) ? (a < b) : (a > b);
  endfunction

  function automatic heap_reply_t apply_heap_op(
      input logic op, input logic signed [bhpq_pkg::VALUE_W-1:0] val);
    heap_reply_t r;
    int idx;
    int par;
    int kid;
    logic signed [bhpq_pkg::VALUE_W-1:0] tmp;
    r.status = bhpq_pkg::STATUS_DONE;
    if (op == bhpq_pkg::OP_INSERT) begin
      if (shadow_count >= HEAP_DEPTH) begin
        r.status = bhpq_pkg::STATUS_FULL;
      end else begin
        shadow_heap[shadow_count] = val;
        idx = shadow_count;
        shadow_count++;
        while (idx > 0) begin
          par = (idx - 1) / 2;
          if (!ranks_above(shadow_heap[idx], shadow_heap[par])) break;
          tmp = shadow_heap[idx];
          shadow_heap[idx] = shadow_heap[par];
          shadow_heap[par] = tmp;
          idx = par;
        end
      end
    end else if (shadow_count == 0) begin
      r.status = bhpq_pkg::STATUS_EMPTY;
    end else begin
      shadow_count--;
      if (shadow_count > 0) begin
        shadow_heap[0] = shadow_heap[shadow_count];
        idx = 0;
        while (2 * idx + 1 < shadow_count) begin
          kid = 2 * idx + 1;
          // right child only when strictly better; ties go left
          if (kid + 1 < shadow_count && ranks_above(shadow_heap[kid + 1], shadow_heap[kid]))
            kid++;
          if (!ranks_above(shadow_heap[kid], shadow_heap[idx])) break;
          tmp = shadow_heap[idx];
          shadow_heap[idx] = shadow_heap[kid];
          shadow_heap[kid] = tmp;
          idx = kid;
        end
      end
    end
    r.top_value = (shadow_count > 0) ? shadow_heap[0] : '0;
    r.element_count = bhpq_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  // mode 0: full range, 1: narrow range (many ties), 2: extremes and near zero
  function automatic logic signed [bhpq_pkg::VALUE_W-1:0] pick_value(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(8) - 4;
      default: begin
        case ($urandom_range(4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 10) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_word(input logic op, input logic signed [bhpq_pkg::VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.value  <= val;
    do @(posedge clk); while (!req_if.ready);
    queued_heap_replies.push_back(apply_heap_op(op, val));
  endtask

  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    while (queued_heap_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_heap_order(input logic order);
    logic [bhpq_pkg::PDATA_W-1:0] junk;
    hold_until_drained();
    repeat (4) @(posedge clk);
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HEAP_ORDER_ADDR;
    pwdata  <= {junk[bhpq_pkg::PDATA_W-1:1], order};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_order = order;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_empty_and_extremes();
    send_word(bhpq_pkg::OP_REMOVE, VAL_MAX);
    send_word(bhpq_pkg::OP_INSERT, '0);
    send_word(bhpq_pkg::OP_INSERT, VAL_MAX);
    send_word(bhpq_pkg::OP_INSERT, VAL_MIN);
    send_word(bhpq_pkg::OP_INSERT, -1);
    send_word(bhpq_pkg::OP_INSERT, 1);
    send_word(bhpq_pkg::OP_INSERT, VAL_MAX);
    send_word(bhpq_pkg::OP_INSERT, VAL_MIN);
    repeat (7) send_word(bhpq_pkg::OP_REMOVE, pick_value(0));
    send_word(bhpq_pkg::OP_REMOVE, '0);
    write_heap_order(bhpq_pkg::ORDER_MIN);
    send_word(bhpq_pkg::OP_INSERT, 5);
    send_word(bhpq_pkg::OP_INSERT, 5);
    send_word(bhpq_pkg::OP_INSERT, 5);
    send_word(bhpq_pkg::OP_INSERT, -3);
    send_word(bhpq_pkg::OP_INSERT, 7);
    send_word(bhpq_pkg::OP_INSERT, VAL_MIN);
    repeat (3) send_word(bhpq_pkg::OP_REMOVE, pick_value(0));
    hold_until_drained();
    write_heap_order(bhpq_pkg::ORDER_MAX);
  endtask

  task automatic test_fill_to_full();
    while (shadow_count < HEAP_DEPTH) begin
      send_word(bhpq_pkg::OP_INSERT, pick_value($urandom_range(2)));
    end
    send_word(bhpq_pkg::OP_INSERT, VAL_MAX);
    send_word(bhpq_pkg::OP_INSERT, VAL_MIN);
    send_word(bhpq_pkg::OP_REMOVE, '0);
    send_word(bhpq_pkg::OP_INSERT, pick_value(0));
    send_word(bhpq_pkg::OP_INSERT, pick_value(0));
    repeat (40) send_word(bhpq_pkg::OP_REMOVE, pick_value(0));
  endtask

  // stored words are not reordered when the order flips under a non-empty heap
  task automatic test_order_switch();
    repeat (12) send_word(bhpq_pkg::OP_INSERT, pick_value(1));
    write_heap_order(~shadow_order);
    repeat (20) send_word(logic'($urandom_range(1)), pick_value(2));
    write_heap_order(~shadow_order);
    while (shadow_count > 0) send_word(bhpq_pkg::OP_REMOVE, pick_value(0));
    send_word(bhpq_pkg::OP_REMOVE, pick_value(0));
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int chunk;
    int insert_pct;
    int value_mode;
    sent = 0;
    while (sent < n_items) begin
      chunk = $urandom_range(20, 60);
      case ($urandom_range(2))
        0: insert_pct = 80;
        1: insert_pct = 50;
        default: insert_pct = 25;
      endcase
      value_mode = $urandom_range(2);
      repeat (chunk) begin
        send_word(($urandom_range(99) < insert_pct) ? bhpq_pkg::OP_INSERT : bhpq_pkg::OP_REMOVE,
                  pick_value(value_mode));
      end
      sent += chunk;
      if ($urandom_range(3) == 0) write_heap_order(logic'($urandom_range(1)));
    end
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (queued_heap_replies.size() == 0) begin
        note_mismatch($sformatf("result word with nothing outstanding: status %0d top %0d count %0d",
                                rsp_if.status, $signed(rsp_if.top_value), rsp_if.element_count));
      end else begin
        want_reply = queued_heap_replies.pop_front();
        if (rsp_if.status !== want_reply.status ||
            rsp_if.top_value !== want_reply.top_value ||
            rsp_if.element_count !== want_reply.element_count) begin
          note_mismatch($sformatf("exp status %0d top %0d count %0d, got status %0d top %0d count %0d",
                                  want_reply.status, $signed(want_reply.top_value),
                                  want_reply.element_count, rsp_if.status,
                                  $signed(rsp_if.top_value), rsp_if.element_count));
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    req_if.valid  <= 1'b0;
    req_if.opcode <= bhpq_pkg::OP_INSERT;
    req_if.value  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    send_idle_pct = 8;
    recv_idle_pct = 57;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_extremes();
    test_fill_to_full();
    test_random_traffic(330);

    send_idle_pct = 57;
    recv_idle_pct = 8;
    test_order_switch();
    test_random_traffic(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(330);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && queued_heap_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
